FILE: hw/rtl/polyline_border_offset_defines.svh
// Assertion macros of the border offset RTL.
`ifndef POLYLINE_BORDER_OFFSET_DEFINES_SVH
`define POLYLINE_BORDER_OFFSET_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clk edge outside reset.
`define PBO_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define PBO_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PBO_ASSERT(label, prop, msg)
`define PBO_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: hw/rtl/pbo_pkg.sv
// Types and constants of the polyline border offset block.
package pbo_pkg;

	localparam int BW_BITS      = 24;
	localparam int MIN_LEN_BITS = 16;
	localparam int CFG_IDX_BITS = 1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_BORDER_WIDTH       = 1'b0,
		REG_MIN_TANGENT_LENGTH = 1'b1
	} cfg_reg_t;

	// Sequencer phases of the shared arithmetic unit
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SQX,
		PH_SQZ,
		PH_ROOT,
		PH_CHECK,
		PH_MULZ,
		PH_DIVZ,
		PH_MULX,
		PH_DIVX
	} core_phase_t;

	// Top level control states
	typedef enum logic [2:0] {
		S_IDLE,
		S_LAUNCH,
		S_RUN,
		S_OUT_A,
		S_OUT_B,
		S_COMMIT
	} top_state_t;

	// Status returned by the offset core
	typedef struct packed {
		logic done;
		logic keep;
	} core_stat_t;

endpackage

FILE: hw/rtl/pbo_core.sv
// Offset core: tangent length and perpendicular offsets on one shared add/subtract unit.
module pbo_core #(
	parameter int COORD_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [COORD_BITS:0]             dx,
	input  logic signed [COORD_BITS:0]             dz,
	input  logic [pbo_pkg::BW_BITS-1:0]            border_width,
	input  logic [pbo_pkg::MIN_LEN_BITS-1:0]       min_tangent_length,
	output pbo_pkg::core_stat_t                    stat,
	output logic signed [((COORD_BITS > pbo_pkg::BW_BITS) ? COORD_BITS : pbo_pkg::BW_BITS) + 1:0] off_x,
	output logic signed [((COORD_BITS > pbo_pkg::BW_BITS) ? COORD_BITS : pbo_pkg::BW_BITS) + 1:0] off_z
);

	localparam int MW = COORD_BITS + 1;
	localparam int BW = pbo_pkg::BW_BITS;
	localparam int XW = (MW > BW) ? MW : BW;
	localparam int AW = MW + XW;
	localparam int RW = MW + 3;
	localparam int OW = ((COORD_BITS > BW) ? COORD_BITS : BW) + 2;
	localparam int CW = $clog2(AW + 1);

	pbo_pkg::core_phase_t phase_q, phase_d;

	logic signed [MW-1:0] dx_q, dz_q;
	logic [AW-1:0]        acc_q, mcand_q;
	logic [XW-1:0]        mplr_q;
	logic [CW-1:0]        cnt_q;
	logic [MW-1:0]        root_q;
	logic [RW-1:0]        rem_q;
	logic [BW-1:0]        qz_q;
	logic signed [OW-1:0] off_x_q, off_z_q;
	logic                 done_q, keep_q;

	logic [MW-1:0]  mag_x, mag_z, mag_in_x;
	logic [RW-1:0]  rem_sh, rem_dv;
	logic [AW-1:0]  alu_a, alu_b;
	logic           alu_sub;
	logic [AW:0]    alu_res;
	logic           ge, cnt0, len_ok;
	logic [BW-1:0]  q_last;

	function automatic logic [MW-1:0] abs_mw(input logic signed [MW-1:0] v);
		abs_mw = v[MW-1] ? MW'(-v) : MW'(v);
	endfunction

	assign mag_x    = abs_mw(dx_q);
	assign mag_z    = abs_mw(dz_q);
	assign mag_in_x = abs_mw(dx);
	assign cnt0     = (cnt_q == '0);
	assign len_ok   = root_q > MW'(min_tangent_length);

	// Bring down two radicand bits for the root, one numerator bit for the divide
	assign rem_sh = {rem_q[RW-3:0], acc_q[2*MW-1 -: 2]};
	assign rem_dv = {rem_q[RW-2:0], acc_q[AW-1]};

	// Shared add/subtract unit
	always_comb begin
		alu_a   = acc_q;
		alu_b   = mcand_q;
		alu_sub = 1'b0;
		case (phase_q)
			pbo_pkg::PH_ROOT: begin
				alu_a   = AW'(rem_sh);
				alu_b   = AW'({root_q, 2'b01});
				alu_sub = 1'b1;
			end
			pbo_pkg::PH_DIVZ, pbo_pkg::PH_DIVX: begin
				alu_a   = AW'(rem_dv);
				alu_b   = AW'({root_q, 1'b0});
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = acc_q;
				alu_b   = mcand_q;
				alu_sub = 1'b0;
			end
		endcase
		alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
	end

	assign ge     = !alu_res[AW];
	assign q_last = {acc_q[BW-2:0], ge};

	// Advance the sequencer
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			pbo_pkg::PH_IDLE:  if (start) phase_d = pbo_pkg::PH_SQX;
			pbo_pkg::PH_SQX:   if (cnt0) phase_d = pbo_pkg::PH_SQZ;
			pbo_pkg::PH_SQZ:   if (cnt0) phase_d = pbo_pkg::PH_ROOT;
			pbo_pkg::PH_ROOT:  if (cnt0) phase_d = pbo_pkg::PH_CHECK;
			pbo_pkg::PH_CHECK: phase_d = len_ok ? pbo_pkg::PH_MULZ : pbo_pkg::PH_IDLE;
			pbo_pkg::PH_MULZ:  if (cnt0) phase_d = pbo_pkg::PH_DIVZ;
			pbo_pkg::PH_DIVZ:  if (cnt0) phase_d = pbo_pkg::PH_MULX;
			pbo_pkg::PH_MULX:  if (cnt0) phase_d = pbo_pkg::PH_DIVX;
			pbo_pkg::PH_DIVX:  if (cnt0) phase_d = pbo_pkg::PH_IDLE;
			default:           phase_d = pbo_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pbo_pkg::PH_IDLE;
			done_q  <= 1'b0;
			keep_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= 1'b0;
			if (phase_q == pbo_pkg::PH_CHECK && !len_ok) begin
				done_q <= 1'b1;
				keep_q <= 1'b0;
			end
			if (phase_q == pbo_pkg::PH_DIVX && cnt0) begin
				done_q <= 1'b1;
				keep_q <= 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (phase_q)
			pbo_pkg::PH_IDLE: begin
				if (start) begin
					dx_q    <= dx;
					dz_q    <= dz;
					acc_q   <= '0;
					mcand_q <= AW'(mag_in_x);
					mplr_q  <= XW'(mag_in_x);
					cnt_q   <= CW'(XW - 1);
				end
			end
			pbo_pkg::PH_SQX, pbo_pkg::PH_SQZ, pbo_pkg::PH_MULZ, pbo_pkg::PH_MULX: begin
				if (mplr_q[0]) acc_q <= alu_res[AW-1:0];
				mcand_q <= mcand_q << 1;
				mplr_q  <= mplr_q >> 1;
				cnt_q   <= cnt_q - 1'b1;
				if (cnt0) begin
					rem_q  <= '0;
					root_q <= '0;
					if (phase_q == pbo_pkg::PH_SQX) begin
						mcand_q <= AW'(mag_z);
						mplr_q  <= XW'(mag_z);
						cnt_q   <= CW'(XW - 1);
					end else if (phase_q == pbo_pkg::PH_SQZ) begin
						cnt_q <= CW'(MW - 1);
					end else begin
						// Keep the tangent length for the divide
						root_q <= root_q;
						cnt_q  <= CW'(AW - 1);
					end
				end
			end
			pbo_pkg::PH_ROOT: begin
				acc_q <= acc_q << 2;
				cnt_q <= cnt_q - 1'b1;
				if (ge) begin
					rem_q  <= alu_res[RW-1:0];
					root_q <= {root_q[MW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[MW-2:0], 1'b0};
				end
			end
			pbo_pkg::PH_CHECK: begin
				acc_q   <= '0;
				mcand_q <= AW'(mag_z);
				mplr_q  <= XW'(border_width);
				cnt_q   <= CW'(XW - 1);
			end
			pbo_pkg::PH_DIVZ, pbo_pkg::PH_DIVX: begin
				acc_q <= {acc_q[AW-2:0], ge};
				rem_q <= ge ? alu_res[RW-1:0] : rem_dv;
				cnt_q <= cnt_q - 1'b1;
				if (cnt0) begin
					if (phase_q == pbo_pkg::PH_DIVZ) begin
						qz_q    <= q_last;
						acc_q   <= '0;
						mcand_q <= AW'(mag_x);
						mplr_q  <= XW'(border_width);
						cnt_q   <= CW'(XW - 1);
					end else begin
						// Rotate the tangent by a quarter turn and apply signs
						off_x_q <= dz_q[MW-1] ? signed'(OW'(qz_q)) : -signed'(OW'(qz_q));
						off_z_q <= dx_q[MW-1] ? -signed'(OW'(q_last)) : signed'(OW'(q_last));
					end
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign stat.done = done_q;
	assign stat.keep = keep_q;
	assign off_x     = off_x_q;
	assign off_z     = off_z_q;

endmodule

FILE: hw/rtl/polyline_border_offset.sv
// Polyline border offset: left and right border points of a centre line.
//
// Input channel (in_valid / in_stall): one centre point per transaction, Q16.16
// coordinates, final_point on the last point of a line. Output channel
// (out_valid / out_stall): one border pair per kept point. A point's result
// appears after its successor arrives; a final point flushes the held point
// and then itself. last_of_run marks the last result caused by one input,
// end_of_line the result of the final point.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 border_width,
// index 1 min_tangent_length; write only while the block is idle.
// One point at a time. Each core job runs on the shared add/subtract unit of the
// offset core, AW = MW + XW bits wide (MW = COORD_BITS+1, XW = max(MW,24)):
// squares, root bit by bit, then two shift-add products and two restoring
// divides; a dropped point ends after the root. A job passes the launch and run
// states, each result the output state, and every point the commit state before
// idle; a first point needs no job. in_stall is high whenever the block is not idle.
// A stalled result holds its fields until taken; the block waits meanwhile.
// Reset clears the line state and loads the register defaults.
`include "polyline_border_offset_defines.svh"

module polyline_border_offset #(
	parameter int COORD_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [COORD_BITS-1:0]           center_x,
	input  logic signed [31:0]                     center_y,
	input  logic signed [COORD_BITS-1:0]           center_z,
	input  logic signed [31:0]                     curvature_in,
	input  logic signed [31:0]                     speed_in,
	input  logic                                   final_point,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [COORD_BITS-1:0]           left_x,
	output logic signed [COORD_BITS-1:0]           left_z,
	output logic signed [COORD_BITS-1:0]           right_x,
	output logic signed [COORD_BITS-1:0]           right_z,
	output logic signed [31:0]                     height_out,
	output logic signed [31:0]                     curvature_out,
	output logic signed [31:0]                     speed_out,
	output logic                                   last_of_run,
	output logic                                   end_of_line,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pbo_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [pbo_pkg::BW_BITS-1:0]            cfg_data
);

	localparam int C  = COORD_BITS;
	localparam int OW = ((C > pbo_pkg::BW_BITS) ? C : pbo_pkg::BW_BITS) + 2;
	localparam logic signed [OW-1:0] SAT_HI = OW'({1'b0, {(C-1){1'b1}}});
	localparam logic signed [OW-1:0] SAT_LO = {{(OW-C+1){1'b1}}, {(C-1){1'b0}}};

	pbo_pkg::top_state_t state_q, state_d;
	pbo_pkg::core_stat_t stat;

	logic [pbo_pkg::BW_BITS-1:0]      border_width_q;
	logic [pbo_pkg::MIN_LEN_BITS-1:0] min_len_q;

	logic signed [C-1:0]  cur_x_q, cur_z_q, held_x_q, held_z_q, prev_x_q, prev_z_q;
	logic signed [31:0]   cur_y_q, cur_curv_q, cur_speed_q;
	logic signed [31:0]   held_y_q, held_curv_q, held_speed_q;
	logic                 fin_q, have_held_q, have_prev_q, job_b_q, keepa_q;
	logic signed [OW-1:0] offa_x_q, offa_z_q, core_off_x, core_off_z;

	logic                 in_acc, out_acc, is_b;
	logic signed [C:0]    base_x, base_z, core_dx, core_dz;
	logic signed [C-1:0]  pt_x, pt_z;
	logic signed [OW-1:0] sel_off_x, sel_off_z, ext_x, ext_z;

	function automatic logic [C-1:0] sat(input logic signed [OW-1:0] v);
		if (v > SAT_HI)
			sat = SAT_HI[C-1:0];
		else if (v < SAT_LO)
			sat = SAT_LO[C-1:0];
		else
			sat = v[C-1:0];
	endfunction

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign in_stall  = (state_q != pbo_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_width_q <= pbo_pkg::BW_BITS'(655360);
			min_len_q      <= pbo_pkg::MIN_LEN_BITS'(66);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pbo_pkg::REG_BORDER_WIDTH:       border_width_q <= cfg_data;
				pbo_pkg::REG_MIN_TANGENT_LENGTH: min_len_q <= cfg_data[pbo_pkg::MIN_LEN_BITS-1:0];
				default:                         min_len_q <= min_len_q;
			endcase
		end
	end

	// Tangent of the job: held point between previous and current, or final point
	always_comb begin
		if (job_b_q) begin
			base_x = have_held_q ? {held_x_q[C-1], held_x_q} : {cur_x_q[C-1], cur_x_q};
			base_z = have_held_q ? {held_z_q[C-1], held_z_q} : {cur_z_q[C-1], cur_z_q};
		end else begin
			base_x = have_prev_q ? {prev_x_q[C-1], prev_x_q} : {held_x_q[C-1], held_x_q};
			base_z = have_prev_q ? {prev_z_q[C-1], prev_z_q} : {held_z_q[C-1], held_z_q};
		end
		core_dx = {cur_x_q[C-1], cur_x_q} - base_x;
		core_dz = {cur_z_q[C-1], cur_z_q} - base_z;
	end

	pbo_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (state_q == pbo_pkg::S_LAUNCH),
		.dx                (core_dx),
		.dz                (core_dz),
		.border_width      (border_width_q),
		.min_tangent_length(min_len_q),
		.stat              (stat),
		.off_x             (core_off_x),
		.off_z             (core_off_z)
	);

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		out_valid = 1'b0;
		case (state_q)
			pbo_pkg::S_IDLE: begin
				if (in_acc)
					state_d = (have_held_q || final_point) ? pbo_pkg::S_LAUNCH : pbo_pkg::S_COMMIT;
			end
			pbo_pkg::S_LAUNCH: state_d = pbo_pkg::S_RUN;
			pbo_pkg::S_RUN: begin
				if (stat.done) begin
					if (!job_b_q) begin
						if (fin_q)
							state_d = pbo_pkg::S_LAUNCH;
						else
							state_d = stat.keep ? pbo_pkg::S_OUT_A : pbo_pkg::S_COMMIT;
					end else if (have_held_q && keepa_q) begin
						state_d = pbo_pkg::S_OUT_A;
					end else begin
						state_d = stat.keep ? pbo_pkg::S_OUT_B : pbo_pkg::S_COMMIT;
					end
				end
			end
			pbo_pkg::S_OUT_A: begin
				out_valid = 1'b1;
				if (out_acc)
					state_d = (fin_q && stat.keep) ? pbo_pkg::S_OUT_B : pbo_pkg::S_COMMIT;
			end
			pbo_pkg::S_OUT_B: begin
				out_valid = 1'b1;
				if (out_acc) state_d = pbo_pkg::S_COMMIT;
			end
			pbo_pkg::S_COMMIT: state_d = pbo_pkg::S_IDLE;
			default:           state_d = pbo_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pbo_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Line state: held point, previous point and their flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_z_q    <= '0;
			have_prev_q <= 1'b0;
			have_held_q <= 1'b0;
			fin_q       <= 1'b0;
			job_b_q     <= 1'b0;
			keepa_q     <= 1'b0;
		end else begin
			if (in_acc) begin
				fin_q   <= final_point;
				job_b_q <= !have_held_q;
			end
			if (state_q == pbo_pkg::S_RUN && stat.done && !job_b_q) begin
				keepa_q <= stat.keep;
				job_b_q <= fin_q;
			end
			if (state_q == pbo_pkg::S_COMMIT) begin
				if (fin_q) begin
					prev_x_q    <= '0;
					prev_z_q    <= '0;
					have_prev_q <= 1'b0;
					have_held_q <= 1'b0;
				end else begin
					if (have_held_q) begin
						prev_x_q <= held_x_q;
						prev_z_q <= held_z_q;
					end
					have_prev_q <= have_held_q;
					have_held_q <= 1'b1;
				end
			end
		end
	end

	// Point payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_x_q     <= center_x;
			cur_y_q     <= center_y;
			cur_z_q     <= center_z;
			cur_curv_q  <= curvature_in;
			cur_speed_q <= speed_in;
		end
		if (state_q == pbo_pkg::S_RUN && stat.done && !job_b_q) begin
			offa_x_q <= core_off_x;
			offa_z_q <= core_off_z;
		end
		if (state_q == pbo_pkg::S_COMMIT) begin
			held_x_q     <= cur_x_q;
			held_y_q     <= cur_y_q;
			held_z_q     <= cur_z_q;
			held_curv_q  <= cur_curv_q;
			held_speed_q <= cur_speed_q;
		end
	end

	// Result fields: held point first, then the final point
	assign is_b      = (state_q == pbo_pkg::S_OUT_B);
	assign pt_x      = is_b ? cur_x_q : held_x_q;
	assign pt_z      = is_b ? cur_z_q : held_z_q;
	assign sel_off_x = is_b ? core_off_x : offa_x_q;
	assign sel_off_z = is_b ? core_off_z : offa_z_q;
	assign ext_x     = OW'(pt_x);
	assign ext_z     = OW'(pt_z);

	assign left_x        = sat(ext_x + sel_off_x);
	assign left_z        = sat(ext_z + sel_off_z);
	assign right_x       = sat(ext_x - sel_off_x);
	assign right_z       = sat(ext_z - sel_off_z);
	assign height_out    = is_b ? cur_y_q : held_y_q;
	assign curvature_out = is_b ? cur_curv_q : held_curv_q;
	assign speed_out     = is_b ? cur_speed_q : held_speed_q;
	assign last_of_run   = is_b || !(fin_q && stat.keep);
	assign end_of_line   = is_b;

	`PBO_ASSERT(a_eol_is_last, (out_valid && end_of_line) |-> last_of_run, "end of line not last")
	`PBO_ASSERT(a_final_clears, (state_q == pbo_pkg::S_COMMIT && fin_q) |=> !have_held_q, "held point survives final")
	`PBO_ASSERT_NEVER(a_done_in_run, stat.done && state_q != pbo_pkg::S_RUN, "core done outside run")

endmodule

FILE: bench/pbo_border_checker.sv
// Border offset checker: predicts border points from accepted transactions and compares.
`timescale 1ns / 1ps

module pbo_border_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic signed [31:0]               center_x,
	input  logic signed [31:0]               center_y,
	input  logic signed [31:0]               center_z,
	input  logic signed [31:0]               curvature_in,
	input  logic signed [31:0]               speed_in,
	input  logic                             final_point,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic signed [31:0]               left_x,
	input  logic signed [31:0]               left_z,
	input  logic signed [31:0]               right_x,
	input  logic signed [31:0]               right_z,
	input  logic signed [31:0]               height_out,
	input  logic signed [31:0]               curvature_out,
	input  logic signed [31:0]               speed_out,
	input  logic                             last_of_run,
	input  logic                             end_of_line,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [pbo_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [pbo_pkg::BW_BITS-1:0]      cfg_data,
	output int                               errors,
	output int                               outstanding
);

	typedef struct {
		logic signed [31:0] x, y, z, curv, speed;
	} center_pt_t;

	typedef struct {
		logic signed [31:0] lx, lz, rx, rz, height, curv, speed;
		logic               last, eol;
	} border_pt_t;

	border_pt_t                  border_q[$];
	logic [pbo_pkg::BW_BITS-1:0] width_reg;
	logic [15:0]                 min_len_reg;
	longint                      prev_x, prev_z;
	bit                          have_prev, have_held;
	center_pt_t                  held;

	assign outstanding = border_q.size();

	// Clamp to the signed 32-bit coordinate range.
	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// trunc(d * width / (2 * len)) with a single rounding toward zero.
	function automatic longint half_width_part(input longint d, input logic [127:0] len);
		logic [127:0] mag, q;
		mag = 128'(d < 0 ? -d : d);
		q = (mag * 128'(width_reg)) / (len << 1);
		return d < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// Offset one center point along its normal; returns 0 when the point is dropped.
	function automatic bit offset_center(input center_pt_t p, input longint px0, input longint pz0,
			input longint nx, input longint nz, input bit eol, output border_pt_t b);
		longint       dx, dz, ox, oz, cx, cz;
		logic [127:0] ax, az, sum, root, trial;
		dx = nx - px0;
		dz = nz - pz0;
		ax = 128'(dx < 0 ? -dx : dx);
		az = 128'(dz < 0 ? -dz : dz);
		sum = ax * ax + az * az;
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			trial = root | (128'd1 << i);
			if (trial * trial <= sum) root = trial;
		end
		b = '{default: '0};
		if (root <= 128'(min_len_reg)) return 0;
		ox = -half_width_part(dz, root);
		oz = half_width_part(dx, root);
		cx = longint'(p.x);
		cz = longint'(p.z);
		b.lx = clamp32(cx + ox);
		b.lz = clamp32(cz + oz);
		b.rx = clamp32(cx - ox);
		b.rz = clamp32(cz - oz);
		b.height = p.y;
		b.curv = p.curv;
		b.speed = p.speed;
		b.eol = eol;
		return 1;
	endfunction

	// Advance the line state by one accepted point and queue its borders.
	task automatic take_center(input center_pt_t cur, input bit is_final);
		border_pt_t b;
		border_pt_t step_q[$];
		longint     nx, nz, hx, hz;
		nx = longint'(cur.x);
		nz = longint'(cur.z);
		if (have_held) begin
			hx = longint'(held.x);
			hz = longint'(held.z);
			if (offset_center(held, have_prev ? prev_x : hx, have_prev ? prev_z : hz,
					nx, nz, 1'b0, b))
				step_q.push_back(b);
			prev_x = hx;
			prev_z = hz;
			have_prev = 1;
		end else begin
			have_prev = 0;
		end
		held = cur;
		have_held = 1;
		if (is_final) begin
			if (offset_center(cur, have_prev ? prev_x : nx, have_prev ? prev_z : nz,
					nx, nz, 1'b1, b))
				step_q.push_back(b);
			have_held = 0;
			have_prev = 0;
			prev_x = 0;
			prev_z = 0;
		end
		if (step_q.size() > 0) step_q[$].last = 1'b1;
		foreach (step_q[i]) border_q.push_back(step_q[i]);
	endtask

	// Report a field mismatch; only the first ten are printed.
	task automatic field_check(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			errors++;
			if (errors <= 10)
				$display("MISMATCH %s: expected %h, got %h at %0t", name, exp, act, $realtime);
		end
	endtask

	// Track registers, input transactions and output transactions.
	always @(posedge clk or negedge arst_n) begin
		center_pt_t c;
		border_pt_t e;
		if (!arst_n) begin
			width_reg <= 24'd655360;
			min_len_reg <= 16'd66;
			prev_x = 0;
			prev_z = 0;
			have_prev = 0;
			have_held = 0;
			border_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (pbo_pkg::cfg_reg_t'(cfg_index))
					pbo_pkg::REG_BORDER_WIDTH:       width_reg <= cfg_data;
					pbo_pkg::REG_MIN_TANGENT_LENGTH: min_len_reg <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (border_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("UNEXPECTED border transaction at %0t", $realtime);
				end else begin
					e = border_q.pop_front();
					field_check("left_x", e.lx, left_x);
					field_check("left_z", e.lz, left_z);
					field_check("right_x", e.rx, right_x);
					field_check("right_z", e.rz, right_z);
					field_check("height_out", e.height, height_out);
					field_check("curvature_out", e.curv, curvature_out);
					field_check("speed_out", e.speed, speed_out);
					field_check("last_of_run", 32'(e.last), 32'(last_of_run));
					field_check("end_of_line", 32'(e.eol), 32'(end_of_line));
				end
			end
			if (in_valid && !in_stall) begin
				c.x = center_x;
				c.y = center_y;
				c.z = center_z;
				c.curv = curvature_in;
				c.speed = speed_in;
				take_center(c, final_point);
			end
		end
	end

	initial errors = 0;

endmodule

FILE: bench/tb_polyline_border_offset.sv
// Top of the border offset testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_polyline_border_offset;

	localparam int SETTLE_CYCLES = 800;
	localparam longint CYCLE_LIMIT = 6000000;

	logic                             clk, arst_n;
	logic                             in_valid, in_stall, out_valid, out_stall;
	logic signed [31:0]               center_x, center_y, center_z, curvature_in, speed_in;
	logic                             final_point;
	logic signed [31:0]               left_x, left_z, right_x, right_z;
	logic signed [31:0]               height_out, curvature_out, speed_out;
	logic                             last_of_run, end_of_line;
	logic                             cfg_valid, cfg_ready;
	logic [pbo_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [pbo_pkg::BW_BITS-1:0]      cfg_data;
	int                               errors, outstanding;
	int                               idle_pct, stall_pct;
	bit                               long_hold_req;
	longint                           cycles;
	logic signed [31:0]               walk_x, walk_z;

	polyline_border_offset i_dut (.*);

	pbo_border_checker i_checker (.*);

	// Clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Stop a hung run.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Stall the output at random; hold it off for a long stretch on request.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_done) begin
				hold_left = 4000;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one center point; return at the edge that accepts it.
	task automatic send_center(input logic [31:0] x, input logic [31:0] z, input bit fin);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		center_x <= x;
		center_z <= z;
		center_y <= $urandom;
		curvature_in <= $urandom;
		speed_in <= $urandom;
		final_point <= fin;
		do @(posedge clk); while (in_stall);
	endtask

	// Drain expected results and let the core finish any dropped point.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input pbo_pkg::cfg_reg_t idx,
			input logic [pbo_pkg::BW_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Next point of a line: mostly a random walk, sometimes a jump, a repeat or extremes.
	task automatic next_point(output logic [31:0] x, output logic [31:0] z);
		int kind;
		kind = $urandom_range(9);
		case (kind)
			0: begin
				walk_x = $urandom;
				walk_z = $urandom;
			end
			1: ;
			2: begin
				walk_x = {$urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
				walk_z = {$urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
			end
			default: begin
				walk_x += $signed($urandom_range(1) ? 1 : -1) * (32'sd1 << $urandom_range(24))
					+ $signed(32'($urandom_range(255)) - 128);
				walk_z += $signed($urandom_range(1) ? 1 : -1) * (32'sd1 << $urandom_range(24))
					+ $signed(32'($urandom_range(255)) - 128);
			end
		endcase
		x = walk_x;
		z = walk_z;
	endtask

	// Send random lines until about n points have gone in; end on a final point.
	task automatic random_lines(input int n);
		logic [31:0] x, z;
		int          len, sent;
		sent = 0;
		while (sent < n) begin
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 10);
			walk_x = $urandom;
			walk_z = $urandom;
			for (int i = 0; i < len; i++) begin
				next_point(x, z);
				send_center(x, z, i == len - 1);
			end
			sent += len;
			// broken line: a lone final point
			if ($urandom_range(7) == 0) begin
				send_center($urandom, $urandom, 1'b1);
				sent++;
			end
		end
	endtask

	initial begin
		in_valid = 0;
		center_x = 0;
		center_y = 0;
		center_z = 0;
		curvature_in = 0;
		speed_in = 0;
		final_point = 0;
		cfg_valid = 0;
		cfg_index = pbo_pkg::REG_BORDER_WIDTH;
		cfg_data = 0;
		idle_pct = 0;
		stall_pct = 0;
		long_hold_req = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: lone final point, short line, flat segments, extremes.
		send_center(32'h0001_0000, 32'h0002_0000, 1'b1);
		send_center(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_center(32'h0001_0000, 32'h0000_0000, 1'b1);
		send_center(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_center(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_center(32'h0000_0000, 32'h0000_0041, 1'b0);
		send_center(32'h0000_0000, 32'h0000_0042, 1'b0);
		send_center(32'h0000_0000, 32'h0000_0086, 1'b1);
		send_center(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_center(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_center(32'h7FFF_FFF0, 32'h7FFF_FFF0, 1'b0);
		send_center(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		wait_idle();
		write_reg(pbo_pkg::REG_BORDER_WIDTH, 24'hFFFFFF);
		write_reg(pbo_pkg::REG_MIN_TANGENT_LENGTH, 24'd0);
		send_center(32'h7FFF_0000, 32'h7FFF_0000, 1'b0);
		send_center(32'h7FFF_0001, 32'h7FFF_0000, 1'b0);
		send_center(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_center(32'h8000_0000, 32'h8000_0001, 1'b1);
		wait_idle();
		write_reg(pbo_pkg::REG_BORDER_WIDTH, 24'd0);
		write_reg(pbo_pkg::REG_MIN_TANGENT_LENGTH, 24'hFFFF);
		send_center(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_center(32'h0003_0000, 32'h0004_0000, 1'b0);
		send_center(32'h0006_0000, 32'h0008_0000, 1'b1);
		wait_idle();

		// Random phases over settings and idling patterns.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 69; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 69; long_hold_req = 1; end
				3: begin idle_pct = 21; stall_pct = 21; end
				4: begin idle_pct = 0;  stall_pct = 0;  end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			case (ph)
				0: begin
					write_reg(pbo_pkg::REG_BORDER_WIDTH, 24'd655360);
					write_reg(pbo_pkg::REG_MIN_TANGENT_LENGTH, 24'd66);
				end
				1: write_reg(pbo_pkg::REG_BORDER_WIDTH, 24'hFFFFFF);
				2: write_reg(pbo_pkg::REG_MIN_TANGENT_LENGTH, 24'hFFFF);
				3: write_reg(pbo_pkg::REG_BORDER_WIDTH, 24'd0);
				default: begin
					write_reg(pbo_pkg::REG_BORDER_WIDTH, 24'($urandom));
					write_reg(pbo_pkg::REG_MIN_TANGENT_LENGTH, 24'($urandom_range(16'hFFFF)));
				end
			endcase
			random_lines(130);
			wait_idle();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
